@@ rtl/bqc_pkg.sv @@
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared widths, register and microcode codes, and the control word layout
// for the multichannel biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 27;
  localparam int STATE_FRAC     = 14;
  localparam int STATE_BITS     = 48;
  localparam int CHANNELS       = 8;
  localparam int CH_BITS        = 3;
  localparam int CFG_INDEX_BITS = 8;
  localparam int STEP_BITS      = 4;

  localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
  localparam int RND_BITS   = PROD_BITS + 1;
  localparam int TERM_SHIFT = COEF_FRAC_BITS - STATE_FRAC;
  localparam int ACC_BITS   = STATE_BITS + 2;
  localparam int MIX_BITS   = PROD_BITS - COEF_FRAC_BITS + 2;

  localparam logic signed [COEF_BITS-1:0] WET_RESET = COEF_BITS'(64'sd1 << COEF_FRAC_BITS);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_FF0     = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FF1     = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FF2     = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FB1     = CFG_INDEX_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FB2     = CFG_INDEX_BITS'(4);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WET     = CFG_INDEX_BITS'(5);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRY     = CFG_INDEX_BITS'(6);
  localparam logic [CFG_INDEX_BITS-1:0] REG_CASCADE = CFG_INDEX_BITS'(7);

  // multiplier operand A select
  localparam logic [1:0] ASEL_SIN = 2'd0;
  localparam logic [1:0] ASEL_Y   = 2'd1;
  localparam logic [1:0] ASEL_X   = 2'd2;

  // multiplier operand B (coefficient) select
  localparam logic [2:0] CSEL_FF0 = 3'd0;
  localparam logic [2:0] CSEL_FF1 = 3'd1;
  localparam logic [2:0] CSEL_FF2 = 3'd2;
  localparam logic [2:0] CSEL_FB1 = 3'd3;
  localparam logic [2:0] CSEL_FB2 = 3'd4;
  localparam logic [2:0] CSEL_WET = 3'd5;
  localparam logic [2:0] CSEL_DRY = 3'd6;

  // accumulator 1 operations
  localparam logic [1:0] A1_NOP     = 2'd0;
  localparam logic [1:0] A1_LOAD_DA = 2'd1;
  localparam logic [1:0] A1_LOAD_DB = 2'd2;
  localparam logic [1:0] A1_SUB     = 2'd3;

  // accumulator 2 operations
  localparam logic [1:0] A2_NOP  = 2'd0;
  localparam logic [1:0] A2_LOAD = 2'd1;
  localparam logic [1:0] A2_SUB  = 2'd2;

  // mix accumulator operations
  localparam logic [1:0] MX_NOP  = 2'd0;
  localparam logic [1:0] MX_LOAD = 2'd1;
  localparam logic [1:0] MX_ADD  = 2'd2;

  // sequencer operations
  localparam logic [1:0] SQ_NEXT = 2'd0;
  localparam logic [1:0] SQ_LOOP = 2'd1;
  localparam logic [1:0] SQ_DONE = 2'd2;

  typedef struct packed {
    logic                 mul_en;
    logic [1:0]           a_sel;
    logic [2:0]           b_sel;
    logic [1:0]           acc1_op;
    logic [1:0]           acc2_op;
    logic                 y_en;
    logic                 save_en;
    logic [1:0]           mix_op;
    logic                 out_en;
    logic [1:0]           seq_op;
    logic [STEP_BITS-1:0] jmp;
  } ctrl_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] ff0;
    logic signed [COEF_BITS-1:0] ff1;
    logic signed [COEF_BITS-1:0] ff2;
    logic signed [COEF_BITS-1:0] fb1;
    logic signed [COEF_BITS-1:0] fb2;
    logic signed [COEF_BITS-1:0] wet;
    logic signed [COEF_BITS-1:0] dry;
    logic                        cascade;
  } cfg_t;

endpackage

@@ rtl/multichannel_biquad_cascade_top.sv @@
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade_top
// Per-channel biquad (one or two cascaded sections) with dry/wet mix.
// The single shared 24x32 multiplier steps through the microcode, so a new
// input is accepted only once the previous item has finished.
// Reset clears all delay state and registers (wet gain to 1.0); no clear pass.
// ----------------------------------------------------------------------------
module multichannel_biquad_cascade_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bqc_pkg::SAMPLE_BITS-1:0]    s_tdata,   // input_sample
  input  logic [bqc_pkg::CH_BITS-1:0]        s_tuser,   // channel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bqc_pkg::SAMPLE_BITS-1:0]    m_tdata,   // output_sample
  output logic [bqc_pkg::CH_BITS-1:0]        m_tuser,   // out_channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bqc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bqc_pkg::COEF_BITS-1:0]      cfg_data
);
  import bqc_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  busy;
  logic  sec;
  logic  out_free;
  logic  start;

  assign s_tready = !busy && !rst;
  assign start    = s_tvalid && s_tready;

  bqc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bqc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cascade  (cfg.cascade),
    .out_free (out_free),
    .busy     (busy),
    .sec      (sec),
    .ctrl     (ctrl)
  );

  bqc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .ctrl     (ctrl),
    .sec      (sec),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .out_free (out_free)
  );

endmodule

@@ rtl/bqc_regs.sv @@
// ----------------------------------------------------------------------------
// bqc_regs
// Configuration register bank: coefficients, gains and cascade select.
// ----------------------------------------------------------------------------
module bqc_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bqc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bqc_pkg::COEF_BITS-1:0]      cfg_data,
  output bqc_pkg::cfg_t                      cfg
);
  import bqc_pkg::*;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ff0     <= '0;
      cfg.ff1     <= '0;
      cfg.ff2     <= '0;
      cfg.fb1     <= '0;
      cfg.fb2     <= '0;
      cfg.wet     <= WET_RESET;
      cfg.dry     <= '0;
      cfg.cascade <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FF0:     cfg.ff0     <= cfg_data;
        REG_FF1:     cfg.ff1     <= cfg_data;
        REG_FF2:     cfg.ff2     <= cfg_data;
        REG_FB1:     cfg.fb1     <= cfg_data;
        REG_FB2:     cfg.fb2     <= cfg_data;
        REG_WET:     cfg.wet     <= cfg_data;
        REG_DRY:     cfg.dry     <= cfg_data;
        REG_CASCADE: cfg.cascade <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/bqc_sequencer.sv @@
// ----------------------------------------------------------------------------
// bqc_sequencer
// Step counter and microcode table; one control word per cycle unless stalled.
// ----------------------------------------------------------------------------
module bqc_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cascade,
  input  logic          out_free,
  output logic          busy,
  output logic          sec,
  output bqc_pkg::ctrl_t ctrl
);
  import bqc_pkg::*;

  localparam logic [STEP_BITS-1:0] STEP_SECTION = STEP_BITS'(0);

  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] a);
    ctrl_t w;
    w = '0;
    case (a)
      4'd0: begin
        w.mul_en = 1'b1; w.a_sel = ASEL_SIN; w.b_sel = CSEL_FF0;
      end
      4'd1: begin
        w.mul_en = 1'b1; w.a_sel = ASEL_SIN; w.b_sel = CSEL_FF1;
        w.acc1_op = A1_LOAD_DA;
      end
      4'd2: begin
        w.mul_en = 1'b1; w.a_sel = ASEL_SIN; w.b_sel = CSEL_FF2;
        w.y_en = 1'b1; w.acc1_op = A1_LOAD_DB;
      end
      4'd3: begin
        w.mul_en = 1'b1; w.a_sel = ASEL_Y; w.b_sel = CSEL_FB1;
        w.acc2_op = A2_LOAD;
      end
      4'd4: begin
        w.mul_en = 1'b1; w.a_sel = ASEL_Y; w.b_sel = CSEL_FB2;
        w.acc1_op = A1_SUB;
      end
      4'd5: begin
        w.acc2_op = A2_SUB;
      end
      4'd6: begin
        w.save_en = 1'b1; w.seq_op = SQ_LOOP; w.jmp = STEP_SECTION;
      end
      4'd7: begin
        w.mul_en = 1'b1; w.a_sel = ASEL_X; w.b_sel = CSEL_DRY;
      end
      4'd8: begin
        w.mul_en = 1'b1; w.a_sel = ASEL_Y; w.b_sel = CSEL_WET;
        w.mix_op = MX_LOAD;
      end
      4'd9: begin
        w.mix_op = MX_ADD;
      end
      4'd10: begin
        w.out_en = 1'b1; w.seq_op = SQ_DONE;
      end
      default: begin
        w.seq_op = SQ_DONE;
      end
    endcase
    return w;
  endfunction

  logic [STEP_BITS-1:0] step;
  ctrl_t                word;
  logic                 hold;

  assign word = ucode(step);
  assign hold = busy && (word.seq_op == SQ_DONE) && !out_free;
  assign ctrl = (busy && !hold) ? word : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sec  <= 1'b0;
      step <= STEP_SECTION;
    end else if (start) begin
      busy <= 1'b1;
      sec  <= 1'b0;
      step <= STEP_SECTION;
    end else if (busy && !hold) begin
      case (word.seq_op)
        SQ_NEXT: step <= step + STEP_BITS'(1);
        SQ_LOOP: begin
          if (cascade && !sec) begin
            step <= word.jmp;
            sec  <= 1'b1;
          end else begin
            step <= step + STEP_BITS'(1);
          end
        end
        default: busy <= 1'b0;
      endcase
    end
  end

endmodule

@@ rtl/bqc_datapath.sv @@
// ----------------------------------------------------------------------------
// bqc_datapath
// Shared multiplier, accumulators, per-channel delay state and output register.
// ----------------------------------------------------------------------------
module bqc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bqc_pkg::SAMPLE_BITS-1:0] s_tdata,
  input  logic [bqc_pkg::CH_BITS-1:0]     s_tuser,
  input  bqc_pkg::cfg_t                   cfg,
  input  bqc_pkg::ctrl_t                  ctrl,
  input  logic                            sec,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [bqc_pkg::SAMPLE_BITS-1:0] m_tdata,
  output logic [bqc_pkg::CH_BITS-1:0]     m_tuser,
  output logic                            out_free
);
  import bqc_pkg::*;

  localparam logic signed [ACC_BITS:0] SMP_MAX =
    {{(ACC_BITS+2-SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS:0] SMP_MIN =
    {{(ACC_BITS+2-SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ST_MAX =
    {{(ACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ST_MIN =
    {{(ACC_BITS-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [ACC_BITS:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v > SMP_MAX) r = SAMPLE_BITS'(SMP_MAX);
    else if (v < SMP_MIN) r = SAMPLE_BITS'(SMP_MIN);
    else r = SAMPLE_BITS'(v);
    return r;
  endfunction

  function automatic logic [STATE_BITS-1:0] sat_state(input logic signed [ACC_BITS-1:0] v);
    logic [STATE_BITS-1:0] r;
    if (v > ST_MAX) r = STATE_BITS'(ST_MAX);
    else if (v < ST_MIN) r = STATE_BITS'(ST_MIN);
    else r = STATE_BITS'(v);
    return r;
  endfunction

  logic signed [STATE_BITS-1:0]  fd1 [CHANNELS];
  logic signed [STATE_BITS-1:0]  fd2 [CHANNELS];
  logic signed [STATE_BITS-1:0]  sd1 [CHANNELS];
  logic signed [STATE_BITS-1:0]  sd2 [CHANNELS];

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] sin;
  logic signed [SAMPLE_BITS-1:0] y;
  logic [CH_BITS-1:0]            ch;
  logic                          ch_ok;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc1;
  logic signed [ACC_BITS-1:0]    acc2;
  logic signed [MIX_BITS-1:0]    mix;

  logic signed [SAMPLE_BITS-1:0] a_op;
  logic signed [COEF_BITS-1:0]   b_op;
  logic signed [STATE_BITS-1:0]  d_a;
  logic signed [STATE_BITS-1:0]  d_b;
  logic signed [RND_BITS-1:0]    term_rnd;
  logic signed [RND_BITS-1:0]    mix_rnd;
  logic signed [ACC_BITS-1:0]    term;
  logic signed [MIX_BITS-1:0]    mix_term;
  logic signed [ACC_BITS:0]      y_rnd;
  logic signed [ACC_BITS:0]      y_shift;

  always_comb begin
    case (ctrl.a_sel)
      ASEL_SIN: a_op = sin;
      ASEL_Y:   a_op = y;
      ASEL_X:   a_op = x;
      default:  a_op = '0;
    endcase
    case (ctrl.b_sel)
      CSEL_FF0: b_op = cfg.ff0;
      CSEL_FF1: b_op = cfg.ff1;
      CSEL_FF2: b_op = cfg.ff2;
      CSEL_FB1: b_op = cfg.fb1;
      CSEL_FB2: b_op = cfg.fb2;
      CSEL_WET: b_op = cfg.wet;
      CSEL_DRY: b_op = cfg.dry;
      default:  b_op = '0;
    endcase
  end

  assign d_a = !ch_ok ? '0 : (sec ? sd1[ch] : fd1[ch]);
  assign d_b = !ch_ok ? '0 : (sec ? sd2[ch] : fd2[ch]);

  assign term_rnd = {prod[PROD_BITS-1], prod} + (RND_BITS'(1) << (TERM_SHIFT - 1));
  assign term     = ACC_BITS'(term_rnd >>> TERM_SHIFT);
  assign mix_rnd  = {prod[PROD_BITS-1], prod} + (RND_BITS'(1) << (COEF_FRAC_BITS - 1));
  assign mix_term = MIX_BITS'(mix_rnd >>> COEF_FRAC_BITS);
  assign y_rnd    = {acc1[ACC_BITS-1], acc1} + ((ACC_BITS+1)'(1) << (STATE_FRAC - 1));
  assign y_shift  = y_rnd >>> STATE_FRAC;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (start) begin
      x     <= s_tdata;
      sin   <= s_tdata;
      ch    <= s_tuser;
      ch_ok <= ({1'b0, s_tuser} < (CH_BITS+1)'(CHANNELS));
    end else if (ctrl.save_en) begin
      sin <= y;
    end
    if (ctrl.mul_en) prod <= a_op * b_op;
    case (ctrl.acc1_op)
      A1_LOAD_DA: acc1 <= term + ACC_BITS'(d_a);
      A1_LOAD_DB: acc1 <= term + ACC_BITS'(d_b);
      A1_SUB:     acc1 <= acc1 - term;
      default: begin
      end
    endcase
    case (ctrl.acc2_op)
      A2_LOAD: acc2 <= term;
      A2_SUB:  acc2 <= acc2 - term;
      default: begin
      end
    endcase
    if (ctrl.y_en) y <= sat_sample(y_shift);
    case (ctrl.mix_op)
      MX_LOAD: mix <= mix_term;
      MX_ADD:  mix <= mix + mix_term;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fd1[i] <= '0;
        fd2[i] <= '0;
        sd1[i] <= '0;
        sd2[i] <= '0;
      end
    end else if (ctrl.save_en && ch_ok) begin
      if (sec) begin
        sd1[ch] <= sat_state(acc1);
        sd2[ch] <= sat_state(acc2);
      end else begin
        fd1[ch] <= sat_state(acc1);
        fd2[ch] <= sat_state(acc2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      m_tdata <= sat_sample((ACC_BITS+1)'(mix));
      m_tuser <= ch;
    end
  end

endmodule

@@ rtl/bqc_checker.sv @@
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks on the biquad cascade, bound to the top level.
// ----------------------------------------------------------------------------
module bqc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [bqc_pkg::SAMPLE_BITS-1:0]    m_tdata,
  input logic [bqc_pkg::CH_BITS-1:0]        m_tuser
);

  logic in_xact;
  assign in_xact = s_tvalid && s_tready;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xact |=> !s_tready)
    else $error("input accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  a_result_ends_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && $past(!s_tready))
    else $error("result appeared without an item finishing");

  a_no_accept_early: assert property (@(posedge clk) disable iff (rst)
    in_xact |=> ##9 !$rose(m_tvalid))
    else $error("result earlier than the shortest program");

endmodule

bind multichannel_biquad_cascade_top bqc_checker u_chk (.*);
